/* hw/rtl/circle_pair_collision_response_unit_assert.svh */
// assertion macros for the circle pair collision response unit
// expects clk and arst_n in the scope of use
`ifndef CIRCLE_PAIR_COLLISION_RESPONSE_UNIT_ASSERT_SVH
`define CIRCLE_PAIR_COLLISION_RESPONSE_UNIT_ASSERT_SVH

// same-cycle implication
`define CPR_ASSERT_NOW(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("cpr assertion failed");

// next-cycle implication
`define CPR_ASSERT_NEXT(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("cpr assertion failed");

`endif

/* hw/rtl/cpr_pkg.sv */
// shared types, constants and helpers for the circle pair collision response unit
// no dependencies
package cpr_pkg;

	localparam int CPR_QDEPTH = 4;
	localparam int PW = 40;
	localparam int SQ_STEPS = 32;
	localparam int MS_STEPS = 24;
	localparam int AX_FIRST = SQ_STEPS + 1;
	localparam int AX_LAST = AX_FIRST + 28;
	localparam int ST_MUL = AX_LAST + 1;
	localparam int ST_SEP = ST_MUL + 1;
	localparam int ST_BNC = ST_SEP + 1;
	localparam int ST_SHR = ST_BNC + 1;
	localparam int ST_IMP = ST_SHR + 1;
	localparam int NST = ST_IMP + 1;

	typedef logic signed [31:0] word_t;
	typedef logic signed [PW-1:0] wpos_t;

	typedef struct packed {
		word_t n1x, n1y, p1x, p1y, n2x, n2y, p2x, p2y;
		logic signed [32:0] dx, dy;
		logic [32:0] rs;
		logic [30:0] m1, m2;
		logic [16:0] e;
		logic near;
	} fr_t;

	typedef struct packed {
		fr_t base;
		logic [63:0] sx, sy;
		logic [65:0] rr;
	} qi_t;

	typedef struct packed {
		wpos_t n1x, n1y, p1x, p1y, n2x, n2y, p2x, p2y;
		logic signed [32:0] dx, dy;
		logic [32:0] rs;
		logic [16:0] e;
		logic close;
		logic imp;
		logic [63:0] v;
		logic [34:0] rem;
		logic [31:0] root;
		logic [31:0] msum;
		logic [32:0] r1, r2;
		logic [23:0] f1, f2;
		logic [32:0] depth, rx, ry;
		logic [28:0] qx, qy;
		logic [61:0] cxm, cym;
		logic signed [65:0] pwx, pwy;
		logic [35:0] sp;
		logic [53:0] ap;
		logic [60:0] gp1, gp2;
		logic [65:0] i1x, i1y, i2x, i2y;
	} bk_t;

	function automatic wpos_t wext(input word_t w);
		return {{(PW-32){w[31]}}, w};
	endfunction

	function automatic logic [31:0] sat(input wpos_t v);
		if (!v[PW-1] && (|v[PW-2:31]))
			return 32'h7FFF_FFFF;
		else if (v[PW-1] && !(&v[PW-2:31]))
			return 32'h8000_0000;
		else
			return v[31:0];
	endfunction

	function automatic wpos_t sgn_ext(input logic neg, input logic [37:0] m);
		wpos_t t;
		t = $signed({{(PW-38){1'b0}}, m});
		return neg ? -t : t;
	endfunction

endpackage

/* hw/rtl/cpr_front.sv */
// front end: takes a circle pair, classifies proximity and squares the offsets
// depends on cpr_pkg
module cpr_front import cpr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [63:0] first_now_xy,
	input logic [63:0] first_prev_xy,
	input logic [63:0] second_now_xy,
	input logic [63:0] second_prev_xy,
	input logic [30:0] first_radius,
	input logic [30:0] second_radius,
	input logic [30:0] first_mass,
	input logic [30:0] second_mass,
	input logic [16:0] first_bounce,
	input logic [16:0] second_bounce,
	output logic q_push,
	output qi_t q_data,
	input logic q_full
);

	fr_t cls;
	fr_t fr_s1;
	qi_t qi_s2;
	logic v_s1, v_s2, fadv;
	logic [32:0] ux, uy, ux1, uy1;
	logic [16:0] bmin;

	assign fadv = !(v_s2 && q_full);
	assign in_stall = !fadv;
	assign q_push = v_s2 && !q_full;
	assign q_data = qi_s2;

	always_comb begin
		cls.n1x = $signed(first_now_xy[63:32]);
		cls.n1y = $signed(first_now_xy[31:0]);
		cls.p1x = $signed(first_prev_xy[63:32]);
		cls.p1y = $signed(first_prev_xy[31:0]);
		cls.n2x = $signed(second_now_xy[63:32]);
		cls.n2y = $signed(second_now_xy[31:0]);
		cls.p2x = $signed(second_prev_xy[63:32]);
		cls.p2y = $signed(second_prev_xy[31:0]);
		cls.dx = {cls.n2x[31], cls.n2x} - {cls.n1x[31], cls.n1x};
		cls.dy = {cls.n2y[31], cls.n2y} - {cls.n1y[31], cls.n1y};
		ux = cls.dx[32] ? 33'(-cls.dx) : 33'(cls.dx);
		uy = cls.dy[32] ? 33'(-cls.dy) : 33'(cls.dy);
		cls.rs = {2'b00, first_radius} + {2'b00, second_radius};
		cls.near = (ux < cls.rs) && (uy < cls.rs);
		cls.m1 = (first_mass == '0) ? 31'd1 : first_mass;
		cls.m2 = (second_mass == '0) ? 31'd1 : second_mass;
		bmin = (first_bounce < second_bounce) ? first_bounce : second_bounce;
		cls.e = (bmin > 17'h10000) ? 17'h10000 : bmin;
	end

	assign ux1 = fr_s1.dx[32] ? 33'(-fr_s1.dx) : 33'(fr_s1.dx);
	assign uy1 = fr_s1.dy[32] ? 33'(-fr_s1.dy) : 33'(fr_s1.dy);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (fadv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fadv) begin
			fr_s1 <= cls;
			qi_s2.base <= fr_s1;
			qi_s2.sx <= 64'(ux1[31:0]) * 64'(ux1[31:0]);
			qi_s2.sy <= 64'(uy1[31:0]) * 64'(uy1[31:0]);
			qi_s2.rr <= 66'(fr_s1.rs) * 66'(fr_s1.rs);
		end
	end

endmodule

/* hw/rtl/cpr_queue.sv */
// short transaction queue between the front end and the back end
// depends on cpr_pkg
module cpr_queue import cpr_pkg::*; #(
	parameter int DEPTH = CPR_QDEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input qi_t wdata,
	output logic full,
	input logic pop,
	output qi_t head,
	output logic empty
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	qi_t mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;

	assign full = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign head = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (pop)
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= wdata;
	end

endmodule

/* hw/rtl/cpr_back.sv */
// back end: square root, axis and mass share division, separation and impulse
// depends on cpr_pkg
module cpr_back import cpr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input qi_t q_head,
	input logic q_empty,
	output logic q_pop,
	output logic out_valid,
	input logic out_stall,
	output logic [63:0] first_new_now_xy,
	output logic [63:0] first_new_prev_xy,
	output logic [63:0] second_new_now_xy,
	output logic [63:0] second_new_prev_xy,
	output logic overlapped,
	output logic impulse_applied
);

	bk_t pipe_q [NST];
	bk_t nx0;
	logic [NST-1:0] vld_q;
	logic adv;
	wpos_t o1x, o1y, o2x, o2y;

	assign adv = !out_valid || !out_stall;
	assign q_pop = adv && !q_empty;

	// stage 0: squared distance and overlap test
	always_comb begin
		logic [64:0] d2;
		d2 = {1'b0, q_head.sx} + {1'b0, q_head.sy};
		nx0 = '0;
		nx0.n1x = wext(q_head.base.n1x);
		nx0.n1y = wext(q_head.base.n1y);
		nx0.p1x = wext(q_head.base.p1x);
		nx0.p1y = wext(q_head.base.p1y);
		nx0.n2x = wext(q_head.base.n2x);
		nx0.n2y = wext(q_head.base.n2y);
		nx0.p2x = wext(q_head.base.p2x);
		nx0.p2y = wext(q_head.base.p2y);
		nx0.dx = q_head.base.dx;
		nx0.dy = q_head.base.dy;
		nx0.rs = q_head.base.rs;
		nx0.e = q_head.base.e;
		nx0.close = q_head.base.near && !d2[64] && ({1'b0, d2} < q_head.rr) && (d2 != '0);
		nx0.v = d2[63:0];
		nx0.msum = {1'b0, q_head.base.m1} + {1'b0, q_head.base.m2};
		nx0.r1 = {2'b00, q_head.base.m2};
		nx0.r2 = {2'b00, q_head.base.m1};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (adv)
			vld_q <= {vld_q[NST-2:0], q_pop};
	end

	always_ff @(posedge clk) begin
		if (adv)
			pipe_q[0] <= nx0;
	end

	for (genvar k = 1; k < NST; k++) begin : g_st
		bk_t p, nxt;
		assign p = pipe_q[k-1];

		if (k <= SQ_STEPS) begin : g_sq
			always_comb begin
				logic [34:0] rm, tr;
				logic [32:0] a1, a2;
				nxt = p;
				rm = {p.rem[32:0], p.v[63:62]};
				tr = {1'b0, p.root, 2'b01};
				nxt.v = {p.v[61:0], 2'b00};
				if (rm >= tr) begin
					nxt.rem = rm - tr;
					nxt.root = {p.root[30:0], 1'b1};
				end else begin
					nxt.rem = rm;
					nxt.root = {p.root[30:0], 1'b0};
				end
				a1 = {p.r1[31:0], 1'b0};
				a2 = {p.r2[31:0], 1'b0};
				if (k <= MS_STEPS) begin
					if (a1 >= {1'b0, p.msum}) begin
						nxt.r1 = a1 - {1'b0, p.msum};
						nxt.f1 = {p.f1[22:0], 1'b1};
					end else begin
						nxt.r1 = a1;
						nxt.f1 = {p.f1[22:0], 1'b0};
					end
					if (a2 >= {1'b0, p.msum}) begin
						nxt.r2 = a2 - {1'b0, p.msum};
						nxt.f2 = {p.f2[22:0], 1'b1};
					end else begin
						nxt.r2 = a2;
						nxt.f2 = {p.f2[22:0], 1'b0};
					end
				end
			end
		end else if (k <= AX_LAST) begin : g_ax
			always_comb begin
				logic [32:0] d, tx, ty;
				nxt = p;
				d = {1'b0, p.root};
				if (k == AX_FIRST) begin
					nxt.depth = p.rs - d;
					tx = p.dx[32] ? 33'(-p.dx) : 33'(p.dx);
					ty = p.dy[32] ? 33'(-p.dy) : 33'(p.dy);
				end else begin
					tx = {p.rx[31:0], 1'b0};
					ty = {p.ry[31:0], 1'b0};
				end
				if (tx >= d) begin
					nxt.rx = tx - d;
					nxt.qx = {p.qx[27:0], 1'b1};
				end else begin
					nxt.rx = tx;
					nxt.qx = {p.qx[27:0], 1'b0};
				end
				if (ty >= d) begin
					nxt.ry = ty - d;
					nxt.qy = {p.qy[27:0], 1'b1};
				end else begin
					nxt.ry = ty;
					nxt.qy = {p.qy[27:0], 1'b0};
				end
			end
		end else if (k == ST_MUL) begin : g_mul
			always_comb begin
				logic signed [35:0] wx, wy;
				logic signed [29:0] axs, ays;
				nxt = p;
				wx = 36'((p.n2x - p.p2x) - (p.n1x - p.p1x));
				wy = 36'((p.n2y - p.p2y) - (p.n1y - p.p1y));
				axs = p.dx[32] ? -$signed({1'b0, p.qx}) : $signed({1'b0, p.qx});
				ays = p.dy[32] ? -$signed({1'b0, p.qy}) : $signed({1'b0, p.qy});
				nxt.pwx = 66'(wx) * 66'(axs);
				nxt.pwy = 66'(wy) * 66'(ays);
				nxt.cxm = 62'(p.qx) * 62'(p.depth);
				nxt.cym = 62'(p.qy) * 62'(p.depth);
			end
		end else if (k == ST_SEP) begin : g_sep
			always_comb begin
				logic [37:0] cx, cy;
				logic signed [66:0] vn;
				logic [66:0] vm;
				wpos_t sx, sy;
				nxt = p;
				cx = 38'((p.cxm + (62'd1 << 28)) >> 29);
				cy = 38'((p.cym + (62'd1 << 28)) >> 29);
				sx = sgn_ext(p.dx[32], cx);
				sy = sgn_ext(p.dy[32], cy);
				if (p.close) begin
					nxt.n1x = p.n1x - sx;
					nxt.n1y = p.n1y - sy;
					nxt.p1x = p.p1x - sx;
					nxt.p1y = p.p1y - sy;
					nxt.n2x = p.n2x + sx;
					nxt.n2y = p.n2y + sy;
					nxt.p2x = p.p2x + sx;
					nxt.p2y = p.p2y + sy;
				end
				vn = 67'(p.pwx) + 67'(p.pwy);
				vm = vn[66] ? 67'(-vn) : 67'(vn);
				nxt.sp = 36'((vm + (67'd1 << 27)) >> 28);
				nxt.imp = p.close && (vn[66] || (vn == '0));
			end
		end else if (k == ST_BNC) begin : g_bnc
			always_comb begin
				nxt = p;
				nxt.ap = 54'(p.sp) * 54'({1'b0, p.e} + 18'h10000);
			end
		end else if (k == ST_SHR) begin : g_shr
			always_comb begin
				logic [36:0] a;
				nxt = p;
				a = 37'((p.ap + (54'd1 << 15)) >> 16);
				nxt.gp1 = 61'(a) * 61'(p.f1);
				nxt.gp2 = 61'(a) * 61'(p.f2);
			end
		end else begin : g_imp
			always_comb begin
				logic [36:0] g1, g2;
				nxt = p;
				g1 = 37'((p.gp1 + (61'd1 << 23)) >> 24);
				g2 = 37'((p.gp2 + (61'd1 << 23)) >> 24);
				nxt.i1x = 66'(p.qx) * 66'(g1);
				nxt.i1y = 66'(p.qy) * 66'(g1);
				nxt.i2x = 66'(p.qx) * 66'(g2);
				nxt.i2y = 66'(p.qy) * 66'(g2);
			end
		end

		always_ff @(posedge clk) begin
			if (adv)
				pipe_q[k] <= nxt;
		end
	end

	// impulse on previous positions, then saturation
	always_comb begin
		bk_t l;
		logic [37:0] s1x, s1y, s2x, s2y;
		l = pipe_q[NST-1];
		s1x = 38'((l.i1x + (66'd1 << 27)) >> 28);
		s1y = 38'((l.i1y + (66'd1 << 27)) >> 28);
		s2x = 38'((l.i2x + (66'd1 << 27)) >> 28);
		s2y = 38'((l.i2y + (66'd1 << 27)) >> 28);
		o1x = l.p1x;
		o1y = l.p1y;
		o2x = l.p2x;
		o2y = l.p2y;
		if (l.imp) begin
			o1x = l.p1x + sgn_ext(l.dx[32], s1x);
			o1y = l.p1y + sgn_ext(l.dy[32], s1y);
			o2x = l.p2x - sgn_ext(l.dx[32], s2x);
			o2y = l.p2y - sgn_ext(l.dy[32], s2y);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (adv)
			out_valid <= vld_q[NST-1];
	end

	always_ff @(posedge clk) begin
		if (adv && vld_q[NST-1]) begin
			first_new_now_xy <= {sat(pipe_q[NST-1].n1x), sat(pipe_q[NST-1].n1y)};
			second_new_now_xy <= {sat(pipe_q[NST-1].n2x), sat(pipe_q[NST-1].n2y)};
			first_new_prev_xy <= {sat(o1x), sat(o1y)};
			second_new_prev_xy <= {sat(o2x), sat(o2y)};
			overlapped <= pipe_q[NST-1].close;
			impulse_applied <= pipe_q[NST-1].imp;
		end
	end

endmodule

/* hw/rtl/circle_pair_collision_response_unit.sv */
// circle pair collision response, top level
// depends on cpr_pkg, cpr_front, cpr_queue, cpr_back
//
// input channel: in_valid / in_stall, one circle pair per transaction, positions
// packed x high word and y low word, signed fixed point.
// output channel: out_valid / out_stall, one corrected pair per transaction
// with overlapped and impulse_applied flags.
// a transaction is taken at a clock edge with valid high and stall low.
// path from input transaction to out_valid: two front stages, the queue,
// 67 back stages (the squared distance stage, 32 square root steps,
// 29 axis division steps, five separation and impulse stages) and the output register.
// throughput: one pair per cycle while out_stall stays low.
// out_stall freezes the back pipeline and the output register; the front
// keeps taking pairs until the queue fills, then raises in_stall.
// reset: arst_n clears every valid flag and the queue; no pair is in flight.
module circle_pair_collision_response_unit import cpr_pkg::*; #(
	parameter int QDEPTH = CPR_QDEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [63:0] first_now_xy,
	input logic [63:0] first_prev_xy,
	input logic [63:0] second_now_xy,
	input logic [63:0] second_prev_xy,
	input logic [30:0] first_radius,
	input logic [30:0] second_radius,
	input logic [30:0] first_mass,
	input logic [30:0] second_mass,
	input logic [16:0] first_bounce,
	input logic [16:0] second_bounce,
	output logic out_valid,
	input logic out_stall,
	output logic [63:0] first_new_now_xy,
	output logic [63:0] first_new_prev_xy,
	output logic [63:0] second_new_now_xy,
	output logic [63:0] second_new_prev_xy,
	output logic overlapped,
	output logic impulse_applied
);

	logic q_push, q_full, q_pop, q_empty;
	qi_t q_wdata, q_head;

	cpr_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.first_now_xy(first_now_xy),
		.first_prev_xy(first_prev_xy),
		.second_now_xy(second_now_xy),
		.second_prev_xy(second_prev_xy),
		.first_radius(first_radius),
		.second_radius(second_radius),
		.first_mass(first_mass),
		.second_mass(second_mass),
		.first_bounce(first_bounce),
		.second_bounce(second_bounce),
		.q_push(q_push),
		.q_data(q_wdata),
		.q_full(q_full)
	);

	cpr_queue #(
		.DEPTH(QDEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.wdata(q_wdata),
		.full(q_full),
		.pop(q_pop),
		.head(q_head),
		.empty(q_empty)
	);

	cpr_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_head(q_head),
		.q_empty(q_empty),
		.q_pop(q_pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.first_new_now_xy(first_new_now_xy),
		.first_new_prev_xy(first_new_prev_xy),
		.second_new_now_xy(second_new_now_xy),
		.second_new_prev_xy(second_new_prev_xy),
		.overlapped(overlapped),
		.impulse_applied(impulse_applied)
	);

endmodule

/* hw/rtl/cpr_checker.sv */
// port-level checks for the circle pair collision response unit
// depends on circle_pair_collision_response_unit_assert.svh; bound to the top level
`include "circle_pair_collision_response_unit_assert.svh"

module cpr_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic [63:0] first_new_now_xy,
	input logic overlapped,
	input logic impulse_applied
);

	`CPR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(first_new_now_xy))
	`CPR_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid)
	`CPR_ASSERT_NOW(a_imp_needs_hit, out_valid && impulse_applied, overlapped)
	`CPR_ASSERT_NOW(a_quiet_after_reset, $rose(arst_n), !out_valid)

endmodule

bind circle_pair_collision_response_unit cpr_checker u_cpr_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_stall(in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.first_new_now_xy(first_new_now_xy),
	.overlapped(overlapped),
	.impulse_applied(impulse_applied)
);

/* bench/circle_pair_collision_response_unit_tb.sv */
// self-checking bench for circle_pair_collision_response_unit: directed and random
// circle pairs, checked against a bit-exact fixed point collision predictor
// depends on cpr_pkg and the unit rtl
module circle_pair_collision_response_unit_tb;
	import cpr_pkg::*;

	typedef struct {
		logic [63:0] n1, p1, n2, p2;
		logic [30:0] r1, r2, m1, m2;
		logic [16:0] b1, b2;
	} pair_t;

	typedef struct {
		logic [63:0] n1, p1, n2, p2;
		logic hit, imp;
	} resp_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [63:0] first_now_xy = 0, first_prev_xy = 0, second_now_xy = 0, second_prev_xy = 0;
	logic [30:0] first_radius = 1, second_radius = 1, first_mass = 1, second_mass = 1;
	logic [16:0] first_bounce = 0, second_bounce = 0;
	logic out_valid;
	logic out_stall = 0;
	logic [63:0] first_new_now_xy, first_new_prev_xy, second_new_now_xy, second_new_prev_xy;
	logic overlapped, impulse_applied;

	resp_t expected_resp[$];
	int errors = 0;
	int sent = 0, hits = 0, impulses = 0;
	int idle_pct = 0, stall_pct = 0;

	circle_pair_collision_response_unit dut (.*);

	always #5 clk = ~clk;

	function automatic longint word_at(logic [63:0] p, bit hi);
		return hi ? longint'($signed(p[63:32])) : longint'($signed(p[31:0]));
	endfunction

	function automatic bit [63:0] magn(longint v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	function automatic bit [63:0] round_shift(bit [63:0] m, int n);
		return (m + (64'd1 << (n - 1))) >> n;
	endfunction

	function automatic longint scale_round(longint v, bit [63:0] u, int n);
		bit [63:0] r;
		r = round_shift(magn(v) * u, n);
		return v < 0 ? -longint'(r) : longint'(r);
	endfunction

	function automatic bit [63:0] int_sqrt(bit [63:0] v);
		bit [63:0] res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic longint unit_comp(longint delta, bit [63:0] d);
		bit [63:0] q;
		q = (magn(delta) << 28) / d;
		if (q > (64'd1 << 28)) q = 64'd1 << 28;
		return delta < 0 ? -longint'(q) : longint'(q);
	endfunction

	function automatic logic [31:0] clamp32(longint v);
		if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
		if (v < -64'sd2147483648) return 32'h8000_0000;
		return v[31:0];
	endfunction

	function automatic resp_t resolve_collision(pair_t it);
		resp_t o;
		longint n1x, n1y, p1x, p1y, n2x, n2y, p2x, p2y, dx, dy, ax, ay, cx, cy, wx, wy, vn;
		bit [63:0] rs, m1, m2, e, ux, uy, sx, sy, d2, d, sp, a, msum, f1, f2, g1, g2;
		bit close;
		n1x = word_at(it.n1, 1); n1y = word_at(it.n1, 0);
		p1x = word_at(it.p1, 1); p1y = word_at(it.p1, 0);
		n2x = word_at(it.n2, 1); n2y = word_at(it.n2, 0);
		p2x = word_at(it.p2, 1); p2y = word_at(it.p2, 0);
		rs = 64'(it.r1) + 64'(it.r2);
		m1 = 64'(it.m1); m2 = 64'(it.m2);
		o.hit = 0; o.imp = 0;
		dx = n2x - n1x; dy = n2y - n1y;
		ux = magn(dx); uy = magn(dy);
		close = (ux < rs) && (uy < rs);
		d2 = 0;
		if (close) begin
			sx = ux * ux; sy = uy * uy;
			d2 = sx + sy;
			if (d2 < sx || d2 >= rs * rs || d2 == 0) close = 0;
		end
		if (close) begin
			d = int_sqrt(d2);
			ax = unit_comp(dx, d); ay = unit_comp(dy, d);
			cx = scale_round(ax, rs - d, 29);
			cy = scale_round(ay, rs - d, 29);
			o.hit = 1;
			n1x -= cx; n1y -= cy; p1x -= cx; p1y -= cy;
			n2x += cx; n2y += cy; p2x += cx; p2y += cy;
			wx = (n2x - p2x) - (n1x - p1x);
			wy = (n2y - p2y) - (n1y - p1y);
			vn = wx * ax + wy * ay;
			if (vn <= 0) begin
				e = 64'(it.b1 < it.b2 ? it.b1 : it.b2);
				if (e > 65536) e = 65536;
				if (m1 == 0) m1 = 1;
				if (m2 == 0) m2 = 1;
				sp = round_shift(magn(vn), 28);
				a = round_shift(sp * (64'd65536 + e), 16);
				msum = m1 + m2;
				f1 = (m2 << 24) / msum;
				f2 = (m1 << 24) / msum;
				g1 = round_shift(a * f1, 24);
				g2 = round_shift(a * f2, 24);
				p1x += scale_round(ax, g1, 28);
				p1y += scale_round(ay, g1, 28);
				p2x -= scale_round(ax, g2, 28);
				p2y -= scale_round(ay, g2, 28);
				o.imp = 1;
			end
		end
		o.n1 = {clamp32(n1x), clamp32(n1y)};
		o.p1 = {clamp32(p1x), clamp32(p1y)};
		o.n2 = {clamp32(n2x), clamp32(n2y)};
		o.p2 = {clamp32(p2x), clamp32(p2y)};
		return o;
	endfunction

	task automatic send_pair(pair_t it);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		first_now_xy <= it.n1; first_prev_xy <= it.p1;
		second_now_xy <= it.n2; second_prev_xy <= it.p2;
		first_radius <= it.r1; second_radius <= it.r2;
		first_mass <= it.m1; second_mass <= it.m2;
		first_bounce <= it.b1; second_bounce <= it.b2;
		do @(posedge clk); while (in_stall);
		expected_resp.push_back(resolve_collision(it));
		sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 0;
		while (expected_resp.size() != 0) @(posedge clk);
	endtask

	function automatic logic [63:0] pack(longint x, longint y);
		return {x[31:0], y[31:0]};
	endfunction

	function automatic logic [16:0] rand_bounce();
		return $urandom_range(9) == 0 ? 17'($urandom) : 17'($urandom_range(65536));
	endfunction

	// a pair whose centre offsets on each axis are at most the radius sum, with random motion
	function automatic pair_t near_pair();
		pair_t it;
		longint x1, y1, ddx, ddy, rsum, spd;
		bit big;
		big = $urandom_range(19) == 0;
		it.r1 = big ? 31'($urandom) : 31'($urandom_range(1, 1 << 20));
		it.r2 = big ? 31'($urandom) : 31'($urandom_range(1, 1 << 20));
		rsum = longint'(it.r1) + longint'(it.r2);
		x1 = longint'($signed(32'($urandom)));
		y1 = longint'($signed(32'($urandom)));
		if (!big && $urandom_range(1)) begin
			x1 = x1 >>> 8; y1 = y1 >>> 8;
		end
		ddx = longint'($urandom_range(32'(rsum > 64'hFFFF_FFFF ? 64'hFFFF_FFFF : rsum)));
		ddy = longint'($urandom_range(32'(rsum > 64'hFFFF_FFFF ? 64'hFFFF_FFFF : rsum)));
		if ($urandom_range(1)) ddx = -ddx;
		if ($urandom_range(1)) ddy = -ddy;
		spd = big ? 64'h7FFF_FFFF : rsum;
		it.n1 = pack(x1, y1);
		it.n2 = pack(x1 + ddx, y1 + ddy);
		it.p1 = pack(x1 + $signed(32'($urandom)) % (spd + 1),
			y1 + $signed(32'($urandom)) % (spd + 1));
		it.p2 = pack(x1 + ddx + $signed(32'($urandom)) % (spd + 1),
			y1 + ddy + $signed(32'($urandom)) % (spd + 1));
		it.m1 = $urandom_range(15) == 0 ? 31'(0) : 31'($urandom);
		it.m2 = $urandom_range(15) == 0 ? 31'(0) : 31'($urandom);
		if ($urandom_range(1)) begin
			it.m1 = it.m1 >> $urandom_range(30);
			it.m2 = it.m2 >> $urandom_range(30);
		end
		it.b1 = rand_bounce();
		it.b2 = rand_bounce();
		return it;
	endfunction

	function automatic pair_t noise_pair();
		pair_t it;
		it.n1 = {$urandom, $urandom}; it.p1 = {$urandom, $urandom};
		it.n2 = {$urandom, $urandom}; it.p2 = {$urandom, $urandom};
		it.r1 = 31'($urandom); it.r2 = 31'($urandom);
		it.m1 = 31'($urandom); it.m2 = 31'($urandom);
		it.b1 = 17'($urandom); it.b2 = 17'($urandom);
		return it;
	endfunction

	function automatic pair_t basic_pair(longint x2, longint y2, longint vx2, longint r);
		pair_t it;
		it.n1 = pack(0, 0); it.p1 = pack(0, 0);
		it.n2 = pack(x2, y2); it.p2 = pack(x2 - vx2, y2);
		it.r1 = 31'(r); it.r2 = 31'(r); it.m1 = 31'(1 << 16); it.m2 = 31'(2 << 16);
		it.b1 = 17'd32768; it.b2 = 17'd65536;
		return it;
	endfunction

	task automatic test_directed();
		pair_t it;
		idle_pct = 0; stall_pct = 0;
		send_pair(basic_pair(10 << 16, 0, 0, 1 << 16));       // far apart
		send_pair(basic_pair(0, 0, 0, 1 << 16));              // coincident centres
		send_pair(basic_pair(1 << 16, 1 << 15, -(1 << 14), 1 << 16)); // approaching
		send_pair(basic_pair(1 << 16, 1 << 15, 1 << 14, 1 << 16));    // separating
		send_pair(basic_pair(1 << 16, 0, 0, 1 << 16));        // zero normal speed
		send_pair(basic_pair(2 << 16, 0, 0, 1 << 16));        // touching exactly
		it = basic_pair(1 << 16, -(1 << 16), -(1 << 16), 1 << 16);
		it.b1 = 17'h1FFFF; it.b2 = 17'h1FFFF;                 // restitution above one
		send_pair(it);
		it.m1 = 0; it.m2 = 0; it.b1 = 0; it.b2 = 0;           // zero mass
		send_pair(it);
		it.m1 = 31'h7FFF_FFFF; it.m2 = 1;
		send_pair(it);
		it = basic_pair(1 << 16, 0, -(1 << 30), 31'h7FFF_FFFF); // huge radius, saturation
		it.n1 = pack(32'sh8000_0000, 32'sh8000_0000);
		it.p1 = pack(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
		it.n2 = pack(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
		it.p2 = pack(32'sh8000_0000, 32'sh8000_0000);
		send_pair(it);
		it.n2 = pack(32'sh8000_0000 + 1, 32'sh8000_0000);
		send_pair(it);
		it.n1 = '1; it.p1 = '1; it.n2 = '1; it.p2 = '1;
		it.r1 = '1; it.r2 = '1; it.m1 = '1; it.m2 = '1; it.b1 = '1; it.b2 = '1;
		send_pair(it);
		it.n1 = 0; it.p1 = 0; it.n2 = 0; it.p2 = 0;
		it.r1 = 0; it.r2 = 0; it.m1 = 0; it.m2 = 0; it.b1 = 0; it.b2 = 0;
		send_pair(it);
		it = basic_pair(0, 1 << 10, 0, 1);                    // tiny radii, near miss
		send_pair(it);
		it = basic_pair(1, 1, 0, 1);
		send_pair(it);
		wait_drained();
	endtask

	task automatic test_random_phase(int ip, int sp, int count);
		idle_pct = ip; stall_pct = sp;
		repeat (count) send_pair($urandom_range(9) < 8 ? near_pair() : noise_pair());
	endtask

	task automatic test_random_stream();
		test_random_phase(0, 0, 400);
		test_random_phase(83, 0, 300);
		wait_drained();
		test_random_phase(0, 83, 300);
		test_random_phase(18, 18, 300);
		test_random_phase(0, 0, 200);
		idle_pct = 0; stall_pct = 0;
	endtask

	always @(posedge clk) begin
		out_stall <= $urandom_range(99) < stall_pct;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_resp.size() == 0) begin
				$display("%0t: unexpected result", $time);
				errors++;
			end else begin
				resp_t x;
				x = expected_resp.pop_front();
				if ({x.n1, x.p1, x.n2, x.p2, x.hit, x.imp} !== {first_new_now_xy,
						first_new_prev_xy, second_new_now_xy, second_new_prev_xy,
						overlapped, impulse_applied}) begin
					$display("%0t: mismatch exp %h %h %h %h %b %b act %h %h %h %h %b %b",
						$time, x.n1, x.p1, x.n2, x.p2, x.hit, x.imp,
						first_new_now_xy, first_new_prev_xy, second_new_now_xy,
						second_new_prev_xy, overlapped, impulse_applied);
					errors++;
				end
				hits += int'(x.hit);
				impulses += int'(x.imp);
			end
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_random_stream();
		wait_drained();
		repeat (150) @(posedge clk);
		$display("sent %0d circle pairs: %0d overlapped, %0d with impulse, under varied idling",
			sent, hits, impulses);
		if (errors == 0 && expected_resp.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#5000000;
		$display("timeout");
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
